FILE: design/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and helpers of the scancode-to-character FIFO.
// ----------------------------------------------------------------------------
package scf_pkg;

   // Character ring
   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   // Keymap store: 128 make codes, plain and shifted column
   localparam int KEYMAP_CODES = 128;
   localparam int KEYMAP_DEPTH = KEYMAP_CODES * 2;
   localparam int KEYMAP_AW    = $clog2(KEYMAP_DEPTH);

   // Register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_LAYOUT_ENABLED = 3'd0
   } csr_addr_type;

   // Request commands
   typedef enum logic [1:0] {
      CMD_SCANCODE = 2'd0,
      CMD_READ     = 2'd1,
      CMD_LOAD     = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   // Set-1 scancodes with a meaning of their own
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam int         SC_BREAK_BIT    = 7;

   // Request held between the keymap lookup and the ring update
   typedef struct packed {
      command_type cmd;
      logic        push;
      logic [7:0]  push_char;
   } stage_type;

   // Advance a ring pointer, wrapping at the ring depth
   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
      logic [RING_AW-1:0] nxt;
      if (ptr == RING_AW'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

FILE: design/scf_req_if.sv
// ----------------------------------------------------------------------------
// scf_req_if
// Request channel: command and its operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] scancode;
   logic [6:0] entry_code;
   logic       entry_shifted;
   logic [7:0] entry_char;

   modport source (
      output valid, command, scancode, entry_code, entry_shifted, entry_char,
      input  ready
   );

   modport sink (
      input  valid, command, scancode, entry_code, entry_shifted, entry_char,
      output ready
   );
endinterface

FILE: design/scf_rsp_if.sv
// ----------------------------------------------------------------------------
// scf_rsp_if
// Result channel: popped character and FIFO status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic       char_valid;
   logic       chars_pending;
   logic       char_dropped;

   modport source (
      output valid, read_char, char_valid, chars_pending, char_dropped,
      input  ready
   );

   modport sink (
      input  valid, read_char, char_valid, chars_pending, char_dropped,
      output ready
   );
endinterface

FILE: design/scf_ram.sv
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-write, single-read RAM with registered, enabled read port.
// ----------------------------------------------------------------------------
module scf_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read data held until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scf_csr.sv
// ----------------------------------------------------------------------------
// scf_csr
// Register port: holds the layout enable and answers reads.
// ----------------------------------------------------------------------------
module scf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [scf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [scf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [scf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output logic                        layout_en
);
   import scf_pkg::*;

   logic layout_en_ff;
   logic layout_en_in;
   logic wr_hit;

   assign csr_pready = 1'b1;

   // Decode on the word address, ignoring byte lanes
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[CSR_AW-1:2] == CSR_LAYOUT_ENABLED[CSR_AW-1:2]);

   always_comb begin
      layout_en_in = layout_en_ff;
      if (wr_hit) begin
         layout_en_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_en_ff <= 1'b0;
      end else begin
         layout_en_ff <= layout_en_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_AW-1:2] == CSR_LAYOUT_ENABLED[CSR_AW-1:2]) begin
         csr_prdata = CSR_DW'(layout_en_ff);
      end
   end

   assign layout_en = layout_en_ff;

endmodule

FILE: design/scf_xlate.sv
// ----------------------------------------------------------------------------
// scf_xlate
// Front stage: shift tracking, keymap load and lookup, request register.
// ----------------------------------------------------------------------------
module scf_xlate (
   input  logic               clock,
   input  logic               reset,
   scf_req_if.sink            req_chan,
   input  logic               layout_en,
   input  logic               stage_take,
   output logic               stage_valid,
   output scf_pkg::stage_type stage
);
   import scf_pkg::*;

   command_type             cmd;
   logic                    accept;
   logic                    shift_make;
   logic                    shift_break;
   logic                    lookup;
   logic                    shift_ff;
   logic                    shift_in;
   logic                    valid_ff;
   logic                    valid_in;
   command_type             cmd_ff;
   command_type             cmd_in;
   logic                    lookup_ff;
   logic                    lookup_in;
   logic                    hit_ff;
   logic                    hit_in;
   logic [KEYMAP_DEPTH-1:0] kvld_ff;
   logic [KEYMAP_DEPTH-1:0] kvld_in;
   logic                    km_we;
   logic [KEYMAP_AW-1:0]    km_waddr;
   logic [KEYMAP_AW-1:0]    km_raddr;
   logic [7:0]              km_rdata;
   logic [7:0]              key_char;

   assign cmd            = command_type'(req_chan.command);
   assign req_chan.ready = !valid_ff || stage_take;
   assign accept         = req_chan.valid && req_chan.ready;

   // Classify the scancode
   assign shift_make  = (req_chan.scancode == SC_LSHIFT_MAKE)
                        || (req_chan.scancode == SC_RSHIFT_MAKE);
   assign shift_break = (req_chan.scancode == SC_LSHIFT_BREAK)
                        || (req_chan.scancode == SC_RSHIFT_BREAK);
   assign lookup      = (cmd == CMD_SCANCODE) && !shift_make && !shift_break
                        && !req_chan.scancode[SC_BREAK_BIT] && layout_en;

   // Keymap addressing: make code and column
   assign km_raddr = {req_chan.scancode[6:0], shift_ff};
   assign km_waddr = {req_chan.entry_code, req_chan.entry_shifted};
   assign km_we    = accept && (cmd == CMD_LOAD);

   scf_ram #(
      .WIDTH (8),
      .DEPTH (KEYMAP_DEPTH)
   ) u_keymap (
      .clock   (clock),
      .wr_en   (km_we),
      .wr_addr (km_waddr),
      .wr_data (req_chan.entry_char),
      .rd_en   (accept && lookup),
      .rd_addr (km_raddr),
      .rd_data (km_rdata)
   );

   // Next state: shift flag, entry valid bits, request register
   always_comb begin
      shift_in  = shift_ff;
      kvld_in   = kvld_ff;
      valid_in  = valid_ff;
      cmd_in    = cmd_ff;
      lookup_in = lookup_ff;
      hit_in    = hit_ff;
      if (accept && (cmd == CMD_SCANCODE)) begin
         if (shift_make) begin
            shift_in = 1'b1;
         end else if (shift_break) begin
            shift_in = 1'b0;
         end
      end
      if (km_we) begin
         kvld_in[km_waddr] = 1'b1;
      end
      if (accept) begin
         valid_in  = 1'b1;
         cmd_in    = cmd;
         lookup_in = lookup;
         hit_in    = kvld_ff[km_raddr];
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         kvld_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         kvld_ff  <= kvld_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      lookup_ff <= lookup_in;
      hit_ff    <= hit_in;
   end

   // An entry never loaded since reset reads as no character
   assign key_char = (lookup_ff && hit_ff) ? km_rdata : 8'd0;

   assign stage_valid     = valid_ff;
   assign stage.cmd       = cmd_ff;
   assign stage.push      = (key_char != 8'd0);
   assign stage.push_char = key_char;

endmodule

FILE: design/scf_ring.sv
// ----------------------------------------------------------------------------
// scf_ring
// Back stage: character ring with one free slot, and the result register.
// ----------------------------------------------------------------------------
module scf_ring (
   input  logic               clock,
   input  logic               reset,
   input  logic               stage_valid,
   input  scf_pkg::stage_type stage,
   output logic               stage_take,
   scf_rsp_if.source          rsp_chan
);
   import scf_pkg::*;

   logic [RING_AW-1:0] wptr_ff;
   logic [RING_AW-1:0] wptr_in;
   logic [RING_AW-1:0] rptr_ff;
   logic [RING_AW-1:0] rptr_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               char_valid_ff;
   logic               char_valid_in;
   logic               pending_ff;
   logic               pending_in;
   logic               dropped_ff;
   logic               dropped_in;
   logic               nonempty;
   logic               full;
   logic               do_push;
   logic               do_pop;
   logic               drop;
   logic [7:0]         ring_rdata;

   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_chan.ready);

   // Ring status
   assign nonempty = (wptr_ff != rptr_ff);
   assign full     = (ring_next(wptr_ff) == rptr_ff);
   assign do_push  = stage_take && (stage.cmd == CMD_SCANCODE) && stage.push && !full;
   assign drop     = (stage.cmd == CMD_SCANCODE) && stage.push && full;
   assign do_pop   = stage_take && (stage.cmd == CMD_READ) && nonempty;

   scf_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wptr_ff),
      .wr_data (stage.push_char),
      .rd_en   (do_pop),
      .rd_addr (rptr_ff),
      .rd_data (ring_rdata)
   );

   // Advance pointers and load the result register
   always_comb begin
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      rsp_valid_in  = rsp_valid_ff;
      char_valid_in = char_valid_ff;
      pending_in    = pending_ff;
      dropped_in    = dropped_ff;
      if (do_push) begin
         wptr_in = ring_next(wptr_ff);
      end
      if (do_pop) begin
         rptr_in = ring_next(rptr_ff);
      end
      if (stage_take) begin
         rsp_valid_in  = 1'b1;
         char_valid_in = do_pop;
         pending_in    = (wptr_in != rptr_in);
         dropped_in    = drop;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_valid_ff <= char_valid_in;
      pending_ff    <= pending_in;
      dropped_ff    <= dropped_in;
   end

   // Ring read data holds until the next pop
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_char     = char_valid_ff ? ring_rdata : 8'd0;
   assign rsp_chan.char_valid    = char_valid_ff;
   assign rsp_chan.chars_pending = pending_ff;
   assign rsp_chan.char_dropped  = dropped_ff;

endmodule

FILE: design/scancode_to_char_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_char_fifo
// Set-1 scancode translator with a keymap store and a character FIFO.
// ----------------------------------------------------------------------------
// Takes one request per clock unless results stall and returns one registered
// result per request, in order. A request is a scancode, a read of one
// character or a load of one keymap entry. The first stage tracks the shift
// keys and reads the 256-entry keymap RAM; the second stage updates the
// character ring and reads it, each RAM being touched once per request, which
// sets the rate of one request per cycle. The result register lets a new
// request in while a result waits to be taken. The keymap reads as all zero
// after reset through one valid flop per entry, so no clearing pass is needed
// and requests are taken from the first cycle after reset. The ring holds at
// most RING_DEPTH-1 characters; a character that finds it full is dropped and
// flagged. Write layout_enabled only while no request is in flight.
// ----------------------------------------------------------------------------
module scancode_to_char_fifo (
   input  logic                        clock,
   input  logic                        reset,
   scf_req_if.sink                     req_chan,
   scf_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [scf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [scf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [scf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import scf_pkg::*;

   logic      layout_en;
   logic      stage_valid;
   logic      stage_take;
   stage_type stage;

   // Register port
   scf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .layout_en   (layout_en)
   );

   // Lookup stage
   scf_xlate u_xlate (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .layout_en   (layout_en),
      .stage_take  (stage_take),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   // Ring stage and result register
   scf_ring u_ring (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .stage_take  (stage_take),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: tb/sv/scf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scf_checker
// Scoreboard for the scancode-to-character FIFO: watches the request, result
// and register channels, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module scf_checker (
   input  logic                       clock,
   input  logic                       reset,
   scf_req_if                         req_mon,
   scf_rsp_if                         rsp_mon,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic                       csr_pready,
   input  logic [scf_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [scf_pkg::CSR_DW-1:0] csr_pwdata,
   output int                         in_flight,
   output int                         fail_count
);
   import scf_pkg::*;

   typedef struct packed {
      logic [7:0] read_char;
      logic       char_valid;
      logic       chars_pending;
      logic       char_dropped;
   } char_result_type;

   // Own copy of the block's state
   logic [7:0]         char_ring [RING_DEPTH];
   logic [7:0]         keymap [KEYMAP_DEPTH];
   logic [RING_AW-1:0] wr_ptr;
   logic [RING_AW-1:0] rd_ptr;
   logic               shift_down;
   logic               layout_on;

   char_result_type predicted_chars[$];

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns: %s mismatch, got 0x%h, expected 0x%h", $time, what, got, want);
      fail_count++;
   endtask

   // Apply one request to the predicted state and work out its result
   task automatic translate_request(input command_type cmd, input logic [7:0] code_byte,
                                    input logic [6:0] ecode, input logic ecol,
                                    input logic [7:0] echar, output char_result_type res);
      logic [7:0]         lookup;
      logic [RING_AW-1:0] wr_next;
      res = '0;
      unique case (cmd)
         CMD_SCANCODE: begin
            if (code_byte == SC_LSHIFT_MAKE || code_byte == SC_RSHIFT_MAKE) begin
               shift_down = 1'b1;
            end else if (code_byte == SC_LSHIFT_BREAK || code_byte == SC_RSHIFT_BREAK) begin
               shift_down = 1'b0;
            end else if (!code_byte[SC_BREAK_BIT] && layout_on) begin
               lookup = keymap[{code_byte[6:0], shift_down}];
               if (lookup != 8'h00) begin
                  wr_next = (wr_ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
                  if (wr_next != rd_ptr) begin
                     char_ring[wr_ptr] = lookup;
                     wr_ptr = wr_next;
                  end else begin
                     res.char_dropped = 1'b1;
                  end
               end
            end
         end
         CMD_READ: begin
            if (wr_ptr != rd_ptr) begin
               res.read_char  = char_ring[rd_ptr];
               res.char_valid = 1'b1;
               rd_ptr = (rd_ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
            end
         end
         CMD_LOAD: begin
            keymap[{ecode, ecol}] = echar;
         end
         default: begin
         end
      endcase
      res.chars_pending = (wr_ptr != rd_ptr);
   endtask

   // Track register writes, predict accepted requests, check taken results
   always @(posedge clock) begin
      char_result_type want;
      char_result_type pred;
      if (reset) begin
         foreach (keymap[i]) keymap[i] = 8'h00;
         wr_ptr     = '0;
         rd_ptr     = '0;
         shift_down = 1'b0;
         layout_on  = 1'b0;
         fail_count = 0;
         predicted_chars.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_LAYOUT_ENABLED) begin
            layout_on = csr_pwdata[0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_chars.size() == 0) begin
               report_mismatch("unexpected result, read_char", rsp_mon.read_char, 8'h00);
            end else begin
               want = predicted_chars.pop_front();
               if (rsp_mon.read_char !== want.read_char)
                  report_mismatch("read_char", rsp_mon.read_char, want.read_char);
               if (rsp_mon.char_valid !== want.char_valid)
                  report_mismatch("char_valid", rsp_mon.char_valid, want.char_valid);
               if (rsp_mon.chars_pending !== want.chars_pending)
                  report_mismatch("chars_pending", rsp_mon.chars_pending,
                                  want.chars_pending);
               if (rsp_mon.char_dropped !== want.char_dropped)
                  report_mismatch("char_dropped", rsp_mon.char_dropped, want.char_dropped);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            translate_request(command_type'(req_mon.command), req_mon.scancode,
                              req_mon.entry_code, req_mon.entry_shifted,
                              req_mon.entry_char, pred);
            predicted_chars.push_back(pred);
         end
      end
      in_flight = predicted_chars.size();
   end

endmodule

FILE: tb/sv/scancode_to_char_fifo_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_char_fifo_tb
// Drives scancodes, reads and keymap loads into the translator with random
// gaps and result stalls, switches the layout register between phases and
// leaves prediction and checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module scancode_to_char_fifo_tb;
   import scf_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              idle_on;
   int                in_flight;
   int                fail_count;

   scf_req_if req_bus ();
   scf_rsp_if rsp_bus ();

   scancode_to_char_fifo DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   scf_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .in_flight   (in_flight),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // Result side: stall in short random bursts while idling is on
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(negedge clock);
      end
   end

   // Present one request and hold it until taken
   task automatic send_request(input command_type cmd, input logic [7:0] code_byte,
                               input logic [6:0] ecode, input logic ecol,
                               input logic [7:0] echar);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.command       = cmd;
      req_bus.scancode      = code_byte;
      req_bus.entry_code    = ecode;
      req_bus.entry_shifted = ecol;
      req_bus.entry_char    = echar;
      req_bus.valid         = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic press(input logic [7:0] code_byte);
      send_request(CMD_SCANCODE, code_byte, 7'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic read_one();
      send_request(CMD_READ, 8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic load_key(input logic [6:0] ecode, input logic ecol, input logic [7:0] echar);
      send_request(CMD_LOAD, 8'($urandom), ecode, ecol, echar);
   endtask

   // Hold off until every predicted result has been taken
   task automatic drain();
      req_bus.valid = 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write through the APB-style port, only while the block is idle
   task automatic write_layout(input logic enable);
      drain();
      csr_paddr     = CSR_LAYOUT_ENABLED;
      csr_pwdata    = $urandom();
      csr_pwdata[0] = enable;
      csr_pwrite    = 1'b1;
      csr_psel      = 1'b1;
      csr_penable   = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // One random request; scancodes mostly hit the loaded keys
   task automatic random_request(input int scan_pct, input int read_pct);
      int roll;
      int pick;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (roll < scan_pct) begin
         if (pick < 6) begin
            press(8'h10 + 8'($urandom_range(0, 15)));
         end else if (pick == 6) begin
            press($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE);
         end else if (pick == 7) begin
            press($urandom_range(0, 1) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK);
         end else begin
            press(8'($urandom_range(0, 255)));
         end
      end else if (roll < scan_pct + read_pct) begin
         read_one();
      end else if (roll < 97) begin
         load_key(7'($urandom_range(0, 127)), 1'($urandom), 8'($urandom_range(0, 255)));
      end else begin
         send_request(CMD_NONE, 8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset         = 1'b1;
      idle_on       = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_NONE;
      req_bus.scancode      = '0;
      req_bus.entry_code    = '0;
      req_bus.entry_shifted = 1'b0;
      req_bus.entry_char    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // An empty read, an ignored command and a scancode with no layout
      read_one();
      send_request(CMD_NONE, 8'hFF, 7'h7F, 1'b1, 8'hFF);
      press(8'h1E);
      load_key(7'h1E, 1'b0, 8'h61);
      load_key(7'h1E, 1'b1, 8'h41);
      load_key(7'h7F, 1'b0, 8'hFF);
      load_key(7'h00, 1'b1, 8'h80);
      write_layout(1'b1);

      // Both shift keys, plain and shifted columns, ignored breaks
      press(8'h1E);
      press(SC_LSHIFT_MAKE);
      press(8'h1E);
      press(8'h00);
      press(SC_LSHIFT_BREAK);
      press(SC_RSHIFT_MAKE);
      press(8'h7F);
      press(SC_RSHIFT_BREAK);
      press(8'h7F);
      press(8'h9E);
      press(8'hFF);
      repeat (5) read_one();
      load_key(7'h1E, 1'b0, 8'h00);
      press(8'h1E);

      // Install keys 0x10..0x1F in both columns
      for (int k = 0; k < 16; k++) begin
         load_key(7'(8'h10 + k), 1'b0, 8'($urandom_range(1, 255)));
         load_key(7'(8'h10 + k), 1'b1, 8'($urandom_range(1, 255)));
      end

      // Fill the ring close to full, so characters may get dropped
      repeat (270) begin
         if ($urandom_range(0, 15) == 0) begin
            press($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_BREAK);
         end else begin
            press(8'h10 + 8'($urandom_range(0, 15)));
         end
      end

      // Mostly reads, with a pause until everything has come back
      repeat (60) random_request(30, 65);
      drain();
      repeat (60) random_request(30, 65);

      // Layout off: scancodes give nothing
      write_layout(1'b0);
      repeat (60) random_request(60, 30);

      // Layout on again, first without idling, then with
      write_layout(1'b1);
      idle_on = 1'b0;
      repeat (100) random_request(55, 40);
      idle_on = 1'b1;
      repeat (60) random_request(50, 40);

      // Last stretch at full rate
      idle_on = 1'b0;
      repeat (40) random_request(50, 40);
      drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/scf_pkg.sv
design/scf_req_if.sv
design/scf_rsp_if.sv
design/scf_ram.sv
design/scf_csr.sv
design/scf_xlate.sv
design/scf_ring.sv
design/scancode_to_char_fifo.sv
tb/sv/scf_checker.sv
tb/sv/scancode_to_char_fifo_tb.sv
